### src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int WORD_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } op_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
    } bdq_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
        logic                     not_empty;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
    } bdq_out_t;

endpackage

### src/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Slot storage: one write port, two registered read ports (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [IW-1:0]            wr_addr,
    input  logic signed [WORD_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [IW-1:0]            rd_addr_a,
    input  logic [IW-1:0]            rd_addr_b,
    output logic signed [WORD_W-1:0] rd_data_a,
    output logic signed [WORD_W-1:0] rd_data_b
);

    logic signed [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of signed words: push/pop at either end, one status
// beat per request beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data  (bdq_in_t: kind, value)
//  m_      | out | m_valid / m_ready  | m_data  (bdq_out_t: status, occupancy,
//          |     |                    |          not_empty, front/back values)
//
//  For each request, the accept cycle updates the pointers, writes the slot
//  RAM and reads front and back in one access; the response state then forms
//  the result from the registered RAM reads (written word forwarded).
//  No new request is taken until the previous result is in the output register.
//  A stalled result holds in the output register; the block waits in its
//  response state until that register frees up.
//  Synchronous active-low reset clears pointers, count and handshake state;
//  slot contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bdq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bdq_out_t m_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

    ctl_state_t state_reg, state_next;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic          fwd_f_reg, fwd_b_reg;
    logic signed [WORD_W-1:0] word_reg;

    logic     m_valid_reg;
    bdq_out_t m_data_reg, m_data_next;

    logic accept;
    logic load;
    logic full, empty, is_push;
    logic wr_en;
    logic [IW-1:0] wr_addr, back_addr;
    logic [IW:0]   sum_wr, sum_back;
    logic signed [WORD_W-1:0] rd_front, rd_back;

    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next pointers and slot write for the incoming request.
    always_comb begin
        full        = (count_reg == DEPTH_C);
        empty       = (count_reg == '0);
        is_push     = (s_data.kind == OP_PUSH_FRONT) || (s_data.kind == OP_PUSH_BACK);
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = head_reg;

        // tail slot = head + count, wrapped (count < DEPTH on a push)
        sum_wr = (IW + 1)'(head_reg) + (IW + 1)'(count_reg);
        if (sum_wr >= DEPTH_S) begin
            sum_wr = sum_wr - DEPTH_S;
        end

        case (s_data.kind)
            OP_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    head_next  = (head_reg == '0) ? LAST_IX : head_reg - 1'b1;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = head_next;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = sum_wr[IW-1:0];
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    head_next  = (head_reg == LAST_IX) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
        endcase

        // back slot = head + count - 1, wrapped; unused when count is zero
        sum_back = (IW + 1)'(head_next) + (IW + 1)'(count_next) - 1'b1;
        if (sum_back >= DEPTH_S) begin
            sum_back = sum_back - DEPTH_S;
        end
        back_addr = sum_back[IW-1:0];
    end

    bdq_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (accept && wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_data.value),
        .rd_en     (accept),
        .rd_addr_a (head_next),
        .rd_addr_b (back_addr),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    // Control FSM and result assembly.
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        load        = 1'b0;
        m_data_next = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                // no beat is taken while reset is held
                s_ready = aresetn;
                if (accept) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_data_next.status      = status_reg;
        m_data_next.occupancy   = OCC_W'(count_reg);
        m_data_next.not_empty   = (count_reg != '0);
        m_data_next.front_value = '0;
        m_data_next.back_value  = '0;
        if (count_reg != '0) begin
            m_data_next.front_value = fwd_f_reg ? word_reg : rd_front;
            m_data_next.back_value  = fwd_b_reg ? word_reg : rd_back;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            word_reg   <= s_data.value;
            // RAM returns old data on a same-cycle write, so flag the bypass
            fwd_f_reg  <= wr_en && is_push && (wr_addr == head_next);
            fwd_b_reg  <= wr_en && is_push && (wr_addr == back_addr);
        end
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("stored count exceeds depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (IW + 1)'(head_reg) < DEPTH_S)
        else $error("head pointer out of range");

    a_accept_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RESP) && !s_ready)
        else $error("request accepted without entering response state");

    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (status_next != ST_DONE)) |=>
            (count_reg == $past(count_reg)) && (head_reg == $past(head_reg)))
        else $error("rejected request changed queue state");

    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (status_next == ST_DONE)) |=>
            (count_reg == $past(count_reg) + 1'b1) ||
            (count_reg == $past(count_reg) - 1'b1))
        else $error("completed request did not move count by one");

endmodule

### tb/deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque, tracks its contents on the side and
// compares every status beat, field by field, with the predicted one.
// ----------------------------------------------------------------------------
module deque_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  bdq_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  bdq_out_t m_data,
    output int       fail_count,
    output int       outstanding,
    output int       results_checked,
    output int       full_rejects,
    output int       empty_rejects,
    output int       peak_fill
);

    logic signed [WORD_W-1:0] ring_words [DEPTH];
    int                       head_pos;
    int                       fill;
    bdq_out_t                 pending_results [$];

    initial begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        full_rejects    = 0;
        empty_rejects   = 0;
        peak_fill       = 0;
        head_pos        = 0;
        fill            = 0;
        foreach (ring_words[i]) ring_words[i] = '0;
    end

    // Applies one request to the shadow deque and returns the status beat it
    // should produce.
    function automatic bdq_out_t apply_deque_op(bdq_in_t req);
        bdq_out_t   res;
        op_status_t st;
        st = ST_DONE;
        case (op_kind_t'(req.kind))
            OP_PUSH_FRONT: begin
                if (fill == DEPTH) begin
                    st = ST_FULL;
                end else begin
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                    ring_words[head_pos] = req.value;
                    fill++;
                end
            end
            OP_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    st = ST_FULL;
                end else begin
                    ring_words[(head_pos + fill) % DEPTH] = req.value;
                    fill++;
                end
            end
            default: begin
                if (fill == 0) begin
                    st = ST_EMPTY;
                end else begin
                    if (op_kind_t'(req.kind) == OP_POP_FRONT)
                        head_pos = (head_pos + 1) % DEPTH;
                    fill--;
                end
            end
        endcase

        res.status      = st;
        res.occupancy   = fill[OCC_W-1:0];
        res.not_empty   = (fill != 0);
        // empty deque reports zero words at both ends
        res.front_value = (fill != 0) ? ring_words[head_pos] : '0;
        res.back_value  = (fill != 0) ? ring_words[(head_pos + fill - 1) % DEPTH] : '0;
        return res;
    endfunction

    task automatic check_field(string fld, int want, int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, fld, want, got);
        end
    endtask

    always @(posedge aclk) begin
        bdq_out_t want;
        if (!aresetn) begin
            pending_results.delete();
            head_pos = 0;
            fill     = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: status beat with no request pending: expected none, got %h",
                             $time, m_data);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("status", want.status, m_data.status);
                    check_field("occupancy", want.occupancy, m_data.occupancy);
                    check_field("not_empty", want.not_empty, m_data.not_empty);
                    check_field("front_value", want.front_value, m_data.front_value);
                    check_field("back_value", want.back_value, m_data.back_value);
                end
            end
            if (s_valid && s_ready) begin
                want = apply_deque_op(s_data);
                if (want.status == ST_FULL)  full_rejects++;
                if (want.status == ST_EMPTY) empty_rejects++;
                if (fill > peak_fill) peak_fill = fill;
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives push/pop requests into the bounded deque: a directed pass over the
// empty and full corners, then random fill/drain phases with random gaps on
// both channels and one long output stall. The checker grades every beat.
// ----------------------------------------------------------------------------
module testbench;
    import bdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_OPS   = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_AT     = 120;
    localparam int STALL_CYCLES = 80;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bdq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bdq_out_t m_data;

    int fail_count, outstanding, results_checked;
    int full_rejects, empty_rejects, peak_fill;

    int cycle_count = 0;
    int sent_count  = 0;
    bit no_idle     = 1'b0;

    bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    deque_checker #(.DEPTH(DEPTH)) checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_rejects    (full_rejects),
        .empty_rejects   (empty_rejects),
        .peak_fill       (peak_fill)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d beats outstanding", $time, outstanding);
            $display("Some tests failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_op(op_kind_t k, logic signed [WORD_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data.kind  <= k;
        s_data.value <= v;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent_count++;
        @(negedge aclk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random back-pressure per beat, one long hold-off partway in.
    initial begin
        int gap;
        int beats;
        beats = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (beats == STALL_AT) gap = STALL_CYCLES;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
            @(negedge aclk);
        end
    end

    initial begin
        int  directed;
        bit  filling;
        int  phase_left;
        int  roll;
        op_kind_t k;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pops, then fill from both ends through the wrap point
        send_op(OP_POP_FRONT, 32'sh1234_5678);
        send_op(OP_POP_BACK, '1);
        send_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'sh8000_0000);
        send_op(OP_PUSH_FRONT, '0);
        send_op(OP_PUSH_BACK, '1);
        for (int i = 0; i < DEPTH - 4; i++)
            send_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
        send_op(OP_PUSH_FRONT, 32'sh5555_5555);
        send_op(OP_PUSH_BACK, 32'shAAAA_AAAA);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);
        directed = sent_count;

        filling    = 1'b1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(15, 40);
                filling    = ~filling;
                no_idle    = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                k = op_kind_t'($urandom_range(0, 3));
            else if ((roll < 80) == filling)
                k = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                k = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            send_op(k, pick_word());
        end
        s_valid <= 1'b0;
        no_idle  = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests (%0d directed), checked %0d status beats.",
                 sent_count, directed, results_checked);
        $display("Full rejections %0d, empty rejections %0d, peak occupancy %0d of %0d.",
                 full_rejects, empty_rejects, peak_fill, DEPTH);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
